// ===== hw/rtl/osts_pkg.sv =====
// ---------------------------------------------------------------------------
// osts_pkg: shared types and constants for the one-shot timer slot table
// Field widths, status codes, the controller states and the result record.
// ---------------------------------------------------------------------------
package osts_pkg;

    localparam int NUM_SLOTS_DEF = 16;

    localparam int TICK_W     = 32;
    localparam int DELAY_W    = 32;
    localparam int TAG_W      = 8;
    localparam int SLOT_OUT_W = 4;
    localparam int STATUS_W   = 2;

    // Stream payload widths, padded to whole bytes
    localparam int IN_FIELDS_W  = DELAY_W + TAG_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + SLOT_OUT_W + TAG_W + TICK_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Selector on the input tuser and kind on the output tuser
    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_TICK   = 1'b1;
    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DELAY = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_REPLY,
        S_TICK,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic                  kind;
        status_t               status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [TAG_W-1:0]      tag;
        logic                  last;
    } result_t;

endpackage

// ===== hw/rtl/one_shot_timer_slots.sv =====
// ---------------------------------------------------------------------------
// one_shot_timer_slots: table of one-shot timers on a free-running tick count
// Adds place a timer in the lowest free slot; ticks report expired slots.
// ---------------------------------------------------------------------------
// Usage: send an add transfer (tuser = 0, tdata = delay and tag) to arm a
// timer in the lowest free slot, or a tick transfer (tuser = 1) to advance
// the counter. Every add gets exactly one response carrying ok, bad delay
// or no free slot; a tick gets one expiry notice per expired slot, in
// ascending slot order, with tlast on the final one, and no response at all
// when nothing expired. Expiry uses the signed 32-bit difference between
// counter and stored expiry, so it stays correct across counter wrap. The
// block handles one item at a time. Expiry times and tags live in a
// single-port synchronous memory read one entry per cycle while the tick
// scan is not held by the output; the active bits are flip-flops cleared
// at reset, so no clearing pass is needed. A bad delay goes straight to
// the reply state; a valid add first runs the one-slot-per-cycle search
// over the active bits from slot 0 up to the lowest free slot or the last
// slot. A tick sweeps every entry once through the memory read port, then
// the compare stage and the final flush of the held notice. The input
// reopens as the add response or the final notice is loaded, or after the
// flush when nothing expired. A stalled output holds the reply, the compare
// stage and the flush. A response waiting on the output register does not
// block acceptance of the next item.
// ---------------------------------------------------------------------------
module one_shot_timer_slots #(
    parameter int NUM_SLOTS = osts_pkg::NUM_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] delay_ticks (signed), [39:32] timer_tag
    input  logic [osts_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // [0] mode
    input  logic                            s_axis_tuser,

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [1:0] status, [5:2] slot, [13:6] expired_tag, [45:14] tick_now
    output logic [osts_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] kind
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MEM_W  = osts_pkg::TICK_W + osts_pkg::TAG_W;
    localparam int PAD_W  = osts_pkg::OUT_TDATA_W - osts_pkg::OUT_FIELDS_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    // Controller
    osts_pkg::state_t state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              scan_done_reg, scan_done_next;

    // Timer state: active bits in flops, expiry and tag in memory
    logic [NUM_SLOTS-1:0]        active_reg, active_next;
    logic [osts_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic [MEM_W-1:0]            mem [NUM_SLOTS];
    logic [MEM_W-1:0]            rd_data_reg;
    logic                        mem_we;
    logic                        mem_re;

    // Pending add
    logic [osts_pkg::TICK_W-1:0] new_exp_reg, new_exp_next;
    logic [osts_pkg::TAG_W-1:0]  new_tag_reg, new_tag_next;
    osts_pkg::result_t           reply_reg, reply_next;

    // Tick scan: compare stage and one-deep hold for tlast marking
    logic              s2_valid_reg, s2_valid_next;
    logic [SLOT_W-1:0] s2_idx_reg, s2_idx_next;
    logic              s2_act_reg, s2_act_next;
    logic              hold_valid_reg, hold_valid_next;
    osts_pkg::result_t hold_reg, hold_next;

    // Output register
    logic                        out_valid_reg, out_valid_next;
    osts_pkg::result_t           out_reg, out_next;
    logic [osts_pkg::TICK_W-1:0] out_tick_reg, out_tick_next;

    logic                         in_xfer;
    logic                         out_free;
    logic                         delay_bad;
    logic [osts_pkg::TICK_W-1:0]  exp_diff;
    logic                         s2_hit;
    logic                         adv;
    logic [osts_pkg::DELAY_W-1:0] in_delay;
    logic [osts_pkg::TAG_W-1:0]   in_tag;

    assign in_delay = s_axis_tdata[osts_pkg::DELAY_W-1:0];
    assign in_tag   = s_axis_tdata[osts_pkg::DELAY_W +: osts_pkg::TAG_W];

    assign s_axis_tready = (state_reg == osts_pkg::S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Zero or negative delays are rejected before any slot search
    assign delay_bad = (in_delay == '0) || in_delay[osts_pkg::DELAY_W-1];

    // Wrap-safe expiry: expired when (tick - expiry) is non-negative
    assign exp_diff = tick_reg - rd_data_reg[MEM_W-1 -: osts_pkg::TICK_W];
    assign s2_hit   = s2_act_reg && !exp_diff[osts_pkg::TICK_W-1];

    // The compare stage moves unless a hit must push the held notice out
    // and the output register is still occupied
    assign adv = !s2_valid_reg || !s2_hit || !hold_valid_reg || out_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            osts_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_axis_tuser == osts_pkg::MODE_TICK)
                        state_next = osts_pkg::S_TICK;
                    else if (delay_bad)
                        state_next = osts_pkg::S_REPLY;
                    else
                        state_next = osts_pkg::S_ADD;
                end
            end
            osts_pkg::S_ADD:
            begin
                if (!active_reg[idx_reg] || (idx_reg == LAST_SLOT))
                    state_next = osts_pkg::S_REPLY;
            end
            osts_pkg::S_REPLY:
            begin
                if (out_free)
                    state_next = osts_pkg::S_IDLE;
            end
            osts_pkg::S_TICK:
            begin
                if (scan_done_reg && !s2_valid_reg)
                    state_next = osts_pkg::S_FLUSH;
            end
            osts_pkg::S_FLUSH:
            begin
                if (!hold_valid_reg || out_free)
                    state_next = osts_pkg::S_IDLE;
            end
            default:
            begin
                state_next = osts_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        idx_next        = idx_reg;
        scan_done_next  = scan_done_reg;
        active_next     = active_reg;
        tick_next       = tick_reg;
        new_exp_next    = new_exp_reg;
        new_tag_next    = new_tag_reg;
        reply_next      = reply_reg;
        s2_valid_next   = s2_valid_reg;
        s2_idx_next     = s2_idx_reg;
        s2_act_next     = s2_act_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_next        = out_reg;
        out_tick_next   = out_tick_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        unique case (state_reg)
            osts_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    idx_next = '0;
                    if (s_axis_tuser == osts_pkg::MODE_TICK)
                    begin
                        tick_next       = tick_reg + 1'b1;
                        scan_done_next  = 1'b0;
                        s2_valid_next   = 1'b0;
                        hold_valid_next = 1'b0;
                    end
                    else
                    begin
                        new_exp_next      = tick_reg + in_delay;
                        new_tag_next      = in_tag;
                        reply_next.kind   = osts_pkg::KIND_ADD;
                        reply_next.status = osts_pkg::ST_BAD_DELAY;
                        reply_next.slot   = '0;
                        reply_next.tag    = '0;
                        reply_next.last   = 1'b1;
                    end
                end
            end
            osts_pkg::S_ADD:
            begin
                // Search one slot per cycle for the lowest free one
                if (!active_reg[idx_reg])
                begin
                    mem_we               = 1'b1;
                    active_next[idx_reg] = 1'b1;
                    reply_next.status    = osts_pkg::ST_OK;
                    reply_next.slot      = osts_pkg::SLOT_OUT_W'(idx_reg);
                end
                else if (idx_reg == LAST_SLOT)
                begin
                    reply_next.status = osts_pkg::ST_FULL;
                    reply_next.slot   = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            osts_pkg::S_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = reply_reg;
                    out_tick_next  = tick_reg;
                end
            end
            osts_pkg::S_TICK:
            begin
                if (adv)
                begin
                    // Compare stage: free a hit slot, push the previous notice
                    if (s2_valid_reg && s2_hit)
                    begin
                        active_next[s2_idx_reg] = 1'b0;
                        if (hold_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = hold_reg;
                            out_next.last  = 1'b0;
                            out_tick_next  = tick_reg;
                        end
                        hold_valid_next  = 1'b1;
                        hold_next.kind   = osts_pkg::KIND_EXPIRY;
                        hold_next.status = osts_pkg::ST_OK;
                        hold_next.slot   = osts_pkg::SLOT_OUT_W'(s2_idx_reg);
                        hold_next.tag    = rd_data_reg[osts_pkg::TAG_W-1:0];
                        hold_next.last   = 1'b1;
                    end
                    // Read stage: issue the next memory read
                    if (!scan_done_reg)
                    begin
                        mem_re        = 1'b1;
                        s2_valid_next = 1'b1;
                        s2_idx_next   = idx_reg;
                        s2_act_next   = active_reg[idx_reg];
                        if (idx_reg == LAST_SLOT)
                            scan_done_next = 1'b1;
                        else
                            idx_next = idx_reg + 1'b1;
                    end
                    else
                    begin
                        s2_valid_next = 1'b0;
                    end
                end
            end
            osts_pkg::S_FLUSH:
            begin
                // The held notice is the final one of this tick
                if (hold_valid_reg && out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = hold_reg;
                    out_next.last   = 1'b1;
                    out_tick_next   = tick_reg;
                    hold_valid_next = 1'b0;
                end
            end
            default:
            begin
                hold_valid_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= osts_pkg::S_IDLE;
            idx_reg        <= '0;
            scan_done_reg  <= 1'b0;
            active_reg     <= '0;
            tick_reg       <= '0;
            s2_valid_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            scan_done_reg  <= scan_done_next;
            active_reg     <= active_next;
            tick_reg       <= tick_next;
            s2_valid_reg   <= s2_valid_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        new_exp_reg  <= new_exp_next;
        new_tag_reg  <= new_tag_next;
        reply_reg    <= reply_next;
        s2_idx_reg   <= s2_idx_next;
        s2_act_reg   <= s2_act_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_tick_reg <= out_tick_next;
    end

    // Slot memory: one port, registered read. A tick only reads and an add
    // only writes, so the same entry is never read and written together.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[idx_reg] <= {new_exp_reg, new_tag_reg};
        if (mem_re)
            rd_data_reg <= mem[idx_reg];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_tick_reg, out_reg.tag, out_reg.slot,
                            out_reg.status};

    // Assertions
    a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (s_axis_tuser == osts_pkg::MODE_TICK))
        |=> (tick_reg == $past(tick_reg) + 1'b1))
        else $error("tick counter did not advance by one on a tick");

    a_hold_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == osts_pkg::S_IDLE) |-> !hold_valid_reg)
        else $error("expiry notice left behind after a tick");

    a_hit_frees_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == osts_pkg::S_TICK) && adv && s2_valid_reg && s2_hit)
        |=> !active_reg[$past(s2_idx_reg)])
        else $error("expired slot not freed");

    a_add_reply_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == osts_pkg::KIND_ADD))
        |-> (m_axis_tlast && (out_reg.tag == '0)))
        else $error("add response without tlast or with a tag");

    a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == osts_pkg::KIND_EXPIRY))
        |-> (out_reg.status == osts_pkg::ST_OK))
        else $error("expiry notice with a non-ok status");

endmodule

// ===== verif/one_shot_timer_slots_tb.sv =====
// ---------------------------------------------------------------------------
// one_shot_timer_slots_tb: self-checking bench for the one-shot timer table
// Streams add and tick transfers into the block, predicts every add response
// and expiry notice from a private copy of the table, and checks each output
// transfer field by field in order, under random sender gaps and receiver
// stalls.
// ---------------------------------------------------------------------------
module one_shot_timer_slots_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = osts_pkg::NUM_SLOTS_DEF;
    localparam int RANDOM_ITEMS = 160;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = 64;   // covers the tail of a tick sweep
    localparam int MAX_LINES    = 40;   // cap on printed mismatch lines

    // One expected output transfer
    typedef struct {
        logic              kind;
        osts_pkg::status_t status;
        logic [3:0]        slot;
        logic [7:0]        tag;
        logic [31:0]       tick_now;
        logic              last;
    } timer_notice_t;

    // Receiver stall styles, switched each time the 8-bit rx_cycle counter wraps
    typedef enum logic [1:0] {
        RX_OPEN,     // always ready
        RX_COIN,     // ready half the time
        RX_SPARSE,   // ready when rx_cycle[2:0] is zero
        RX_MOSTLY    // ready three quarters of the time
    } rx_style_t;

    // -----------------------------------------------------------------------
    // Scoreboard: mirrors the slot table and holds pending notices in order
    // -----------------------------------------------------------------------
    class timer_board;
        bit [31:0]     tick_cnt;
        bit            armed[SLOTS];
        bit [31:0]     due_at[SLOTS];
        bit [7:0]      owner_tag[SLOTS];
        timer_notice_t notice_q[$];

        // Apply one accepted item to the table and queue what it causes
        function void note_input(logic mode, logic [31:0] delay, logic [7:0] tag);
            timer_notice_t n;
            int            free_slot;
            int            first_new;
            bit [31:0]     diff;
            n.kind     = osts_pkg::KIND_ADD;
            n.status   = osts_pkg::ST_OK;
            n.slot     = '0;
            n.tag      = '0;
            n.tick_now = tick_cnt;
            n.last     = 1'b1;
            if (mode == osts_pkg::MODE_ADD) begin
                if (delay == 32'd0 || delay[31]) begin
                    n.status = osts_pkg::ST_BAD_DELAY;
                end
                else begin
                    free_slot = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (!armed[i] && free_slot < 0)
                            free_slot = i;
                    if (free_slot < 0) begin
                        n.status = osts_pkg::ST_FULL;
                    end
                    else begin
                        armed[free_slot]     = 1'b1;
                        due_at[free_slot]    = tick_cnt + delay;
                        owner_tag[free_slot] = tag;
                        n.slot               = free_slot[3:0];
                    end
                end
                notice_q.push_back(n);
            end
            else begin
                tick_cnt  = tick_cnt + 32'd1;
                first_new = notice_q.size();
                for (int i = 0; i < SLOTS; i++) begin
                    diff = tick_cnt - due_at[i];
                    if (armed[i] && !diff[31]) begin
                        n.kind     = osts_pkg::KIND_EXPIRY;
                        n.status   = osts_pkg::ST_OK;
                        n.slot     = i[3:0];
                        n.tag      = owner_tag[i];
                        n.tick_now = tick_cnt;
                        n.last     = 1'b0;
                        notice_q.push_back(n);
                        armed[i] = 1'b0;
                    end
                end
                // mark the final notice of this tick
                if (notice_q.size() > first_new) begin
                    n      = notice_q.pop_back();
                    n.last = 1'b1;
                    notice_q.push_back(n);
                end
            end
        endfunction

        // Compare one output transfer with the oldest notice; empty if it matches
        function string check_result(logic kind, logic [1:0] status, logic [3:0] slot,
                                     logic [7:0] tag, logic [31:0] tick_now, logic last);
            timer_notice_t want;
            string         bad;
            if (notice_q.size() == 0)
                return $sformatf(
                    "unexpected transfer kind=%0b status=%0d slot=%0d tag=%0h tick=%0d",
                    kind, status, slot, tag, tick_now);
            want = notice_q.pop_front();
            bad  = "";
            if (kind !== want.kind)
                bad = {bad, $sformatf(" kind %0b/%0b", kind, want.kind)};
            if (status !== want.status)
                bad = {bad, $sformatf(" status %0d/%0d", status, want.status)};
            if (slot !== want.slot)
                bad = {bad, $sformatf(" slot %0d/%0d", slot, want.slot)};
            if (tag !== want.tag)
                bad = {bad, $sformatf(" tag %0h/%0h", tag, want.tag)};
            if (tick_now !== want.tick_now)
                bad = {bad, $sformatf(" tick %0d/%0d", tick_now, want.tick_now)};
            if (last !== want.last)
                bad = {bad, $sformatf(" last %0b/%0b", last, want.last)};
            if (bad != "")
                return {"field mismatch (got/expected):", bad};
            return "";
        endfunction

        function int pending();
            return notice_q.size();
        endfunction

        function int armed_count();
            int c;
            c = 0;
            for (int i = 0; i < SLOTS; i++)
                c += armed[i];
            return c;
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Signals and block under test
    // -----------------------------------------------------------------------
    logic                             clk;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    // [31:0] delay_ticks, [39:32] timer_tag
    logic [osts_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                             s_axis_tuser;   // [0] mode
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    // [1:0] status, [5:2] slot, [13:6] tag, [45:14] tick_now
    logic [osts_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tuser;   // [0] kind
    logic                             m_axis_tlast;

    timer_board board;
    int         errors;
    int         burst_left;
    bit         valid_held;
    int         cycle_count;
    logic [7:0] rx_cycle;
    rx_style_t  rx_style;
    string      mismatch_text;

    one_shot_timer_slots #(
        .NUM_SLOTS (SLOTS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // -----------------------------------------------------------------------
    // Mismatch reporting: one line per failure, counted; printing is capped
    // -----------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_LINES)
            $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // -----------------------------------------------------------------------
    // Watchdog: end the run if it hangs
    // -----------------------------------------------------------------------
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d transfers still expected",
                     cycle_count, board.pending());
            $display("one_shot_timer_slots_tb: done, errors");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: hold tready on a pattern that changes style as rx_cycle wraps,
    // so stalls land on both add responses and runs of expiry notices
    // -----------------------------------------------------------------------
    always @(posedge clk) begin
        rx_cycle <= rx_cycle + 8'd1;
        if (rx_cycle == 8'd0)
            rx_style <= rx_style_t'($urandom_range(0, 3));
        case (rx_style)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: m_axis_tready <= (rx_cycle[2:0] == 3'd0);
            default:   m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // -----------------------------------------------------------------------
    // Monitor: check every output transfer against the oldest expected one
    // -----------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            mismatch_text = board.check_result(m_axis_tuser, m_axis_tdata[1:0],
                                               m_axis_tdata[5:2], m_axis_tdata[13:6],
                                               m_axis_tdata[45:14], m_axis_tlast);
            if (mismatch_text != "")
                report_mismatch(mismatch_text);
        end
    end

    // -----------------------------------------------------------------------
    // Sender: present one item and hold it until the transfer; items go out
    // in bursts, and a random gap follows each burst
    // -----------------------------------------------------------------------
    task automatic send_item(input logic mode, input logic [31:0] delay,
                             input logic [7:0] tag);
        int gap;
        if (burst_left == 0)
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tag, delay};
        s_axis_tuser  <= mode;
        valid_held = 1'b1;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        board.note_input(mode, delay, tag);
        burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 24);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                valid_held = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Tick data is ignored by the block, so fill it with noise
    task automatic send_tick();
        send_item(osts_pkg::MODE_TICK, $urandom(), 8'($urandom_range(0, 255)));
    endtask

    // Drop tvalid and hold off until every expected transfer has come out
    task automatic drain_results();
        if (valid_held) begin
            s_axis_tvalid <= 1'b0;
            valid_held = 1'b0;
        end
        do @(posedge clk); while (board.pending() != 0);
        burst_left = 0;
    endtask

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial begin
        int          pick;
        logic [31:0] dly;

        board         = new();
        errors        = 0;
        burst_left    = 0;
        valid_held    = 1'b0;
        cycle_count   = 0;
        rx_cycle      = 8'd0;
        rx_style      = RX_OPEN;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= osts_pkg::MODE_ADD;
        m_axis_tready <= 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: rejected delays (zero, most negative, minus one)
        send_item(osts_pkg::MODE_ADD, 32'h0000_0000, 8'hFF);
        send_item(osts_pkg::MODE_ADD, 32'h8000_0000, 8'hA5);
        send_item(osts_pkg::MODE_ADD, 32'hFFFF_FFFF, 8'h5A);
        // A tick with nothing armed: counter advances, no output
        send_tick();
        // Fill the whole table with short timers due on three different ticks
        for (int i = 0; i < SLOTS; i++)
            send_item(osts_pkg::MODE_ADD, 32'd1 + (i % 3), 8'(i * 17));
        // Table full, with the largest legal delay
        send_item(osts_pkg::MODE_ADD, 32'h7FFF_FFFF, 8'hFF);
        // Expire everything: several notices per tick, tlast on the final one
        repeat (3) send_tick();
        drain_results();

        // Random: mostly short timers and ticks so slots turn over and the
        // table sometimes fills; negative rejected delays carry random lower bits
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_tick();
            end
            else if (pick < 50) begin
                dly = ($urandom_range(0, 3) == 0) ? 32'd0 : {1'b1, 31'($urandom())};
                send_item(osts_pkg::MODE_ADD, dly, 8'($urandom_range(0, 255)));
            end
            else if (pick < 58) begin
                send_item(osts_pkg::MODE_ADD, $urandom_range(4, 60),
                          8'($urandom_range(0, 255)));
            end
            else begin
                send_item(osts_pkg::MODE_ADD, $urandom_range(1, 6),
                          8'($urandom_range(0, 255)));
            end
            // hold off now and then until the output side has caught up
            if (n % 50 == 49)
                drain_results();
        end

        // Let every armed timer run out so the long ones below get slots
        while (board.armed_count() > 0)
            send_tick();

        // Large delays up to the signed limit: accepted and left armed
        send_item(osts_pkg::MODE_ADD, 32'h7FFF_FFFF, 8'($urandom_range(0, 255)));
        send_item(osts_pkg::MODE_ADD, 32'h7FFF_FFFE, 8'($urandom_range(0, 255)));
        send_item(osts_pkg::MODE_ADD, 32'h4000_0000, 8'($urandom_range(0, 255)));
        send_item(osts_pkg::MODE_ADD, 32'h2AAA_AAAA, 8'($urandom_range(0, 255)));
        send_item(osts_pkg::MODE_ADD, 32'h5555_5555, 8'($urandom_range(0, 255)));
        repeat (4) send_tick();

        // Wait out the remaining transfers, then the tail of a last sweep
        drain_results();
        repeat (SETTLE_WAIT) @(posedge clk);

        if (board.pending() != 0)
            report_mismatch($sformatf("%0d expected transfers never arrived",
                                      board.pending()));

        if (errors == 0)
            $display("one_shot_timer_slots_tb: done, clean");
        else
            $display("one_shot_timer_slots_tb: done, errors");
        $finish;
    end

endmodule
